// File: design/cabb_pkg.sv
`timescale 1ns / 1ps

package cabb_pkg;

  localparam int DIM_W       = 13;
  localparam int ORG_W       = 14;
  localparam int IDX_W       = 24;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int REG_COUNT   = 7;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [DIM_W-1:0] RST_FRAME_PITCH   = 13'd640;
  localparam logic [DIM_W-1:0] RST_BITMAP_WIDTH  = 13'd64;
  localparam logic [DIM_W-1:0] RST_BITMAP_HEIGHT = 13'd64;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_FRAME_PITCH   = 3'd2,
    REG_BITMAP_WIDTH  = 3'd3,
    REG_BITMAP_HEIGHT = 3'd4,
    REG_ORIGIN_X      = 3'd5,
    REG_ORIGIN_Y      = 3'd6
  } reg_index_e;

  typedef struct packed {
    logic [31:0] src_pixel;
    logic [23:0] dst_pixel;
  } pair_t;

  typedef struct packed {
    logic [23:0] blended_pixel;
    logic [23:0] dest_index;
    logic [23:0] source_index;
    logic        is_last;
    logic        in_region;
  } result_t;

  typedef struct packed {
    logic [31:0] src_pixel;
    logic [23:0] dst_pixel;
    logic [23:0] dest_index;
    logic [23:0] source_index;
    logic        is_last;
    logic        in_region;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

// File: design/cabb_front.sv
`timescale 1ns / 1ps

module cabb_front import cabb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  pair_t             pair,
  input  q_stat_t           q_stat,
  output logic              wr_en,
  output work_t             wr_item
);

  logic [DIM_W-1:0]        frame_width, frame_height, frame_pitch;
  logic [DIM_W-1:0]        bitmap_width, bitmap_height;
  logic signed [ORG_W-1:0] origin_x, origin_y;
  logic [1:0]              busy;

  logic       cfg_wr, cfg_hit, accept;
  reg_index_e cfg_idx;

  // clip stage
  logic [DIM_W-1:0]  fw, fh, bw, bh, pitch;
  logic signed [15:0] ox_e, oy_e, maxx_raw, maxy_raw, minx_e, miny_e, maxx_e, maxy_e;
  logic signed [15:0] offx_e, offy_e;
  logic [DIM_W-1:0]   a_min_x, a_min_y, a_bw, a_bh, a_pitch;
  logic signed [15:0] a_max_x, a_max_y;
  logic [ORG_W-1:0]   a_off_x, a_off_y;
  logic               a_region;

  // start stage
  logic signed [15:0] width_m1_e, last_y_e, row_e;
  logic [25:0]        src_prod, dst_prod;
  logic [IDX_W-1:0]   src_start;
  logic [DIM_W-1:0]   b_min_x, b_min_y, b_width_m1, b_last_y, b_bw, b_pitch;
  logic [IDX_W-1:0]   b_src_start, b_dst_start;
  logic               b_region;

  // walk
  logic [DIM_W-1:0] col, cur_x, cur_y;
  logic [IDX_W-1:0] src_row, dst_row;
  logic             row_end, is_last;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_e'(paddr[4:2]);
  assign full    = (busy != 2'd0) || q_stat.full;
  assign accept  = push && !full;
  assign wr_en   = accept;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_idx)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_FRAME_PITCH, REG_BITMAP_WIDTH,
      REG_BITMAP_HEIGHT, REG_ORIGIN_X, REG_ORIGIN_Y: cfg_hit = cfg_wr;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:   prdata = {19'd0, frame_width};
      REG_FRAME_HEIGHT:  prdata = {19'd0, frame_height};
      REG_FRAME_PITCH:   prdata = {19'd0, frame_pitch};
      REG_BITMAP_WIDTH:  prdata = {19'd0, bitmap_width};
      REG_BITMAP_HEIGHT: prdata = {19'd0, bitmap_height};
      REG_ORIGIN_X:      prdata = {{18{origin_x[ORG_W-1]}}, origin_x};
      REG_ORIGIN_Y:      prdata = {{18{origin_y[ORG_W-1]}}, origin_y};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      frame_pitch   <= RST_FRAME_PITCH;
      bitmap_width  <= RST_BITMAP_WIDTH;
      bitmap_height <= RST_BITMAP_HEIGHT;
      origin_x      <= '0;
      origin_y      <= '0;
      busy          <= 2'd3;
    end else begin
      if (cfg_hit) begin
        busy <= 2'd3;
        unique case (cfg_idx)
          REG_FRAME_WIDTH:   frame_width   <= pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT:  frame_height  <= pwdata[DIM_W-1:0];
          REG_FRAME_PITCH:   frame_pitch   <= pwdata[DIM_W-1:0];
          REG_BITMAP_WIDTH:  bitmap_width  <= pwdata[DIM_W-1:0];
          REG_BITMAP_HEIGHT: bitmap_height <= pwdata[DIM_W-1:0];
          REG_ORIGIN_X:      origin_x      <= pwdata[ORG_W-1:0];
          REG_ORIGIN_Y:      origin_y      <= pwdata[ORG_W-1:0];
          default: ;
        endcase
      end else if (busy != 2'd0) begin
        busy <= busy - 2'd1;
      end
    end
  end

  // clip rectangle
  always_comb begin
    fw       = sat_dim(frame_width);
    fh       = sat_dim(frame_height);
    bw       = sat_dim(bitmap_width);
    bh       = sat_dim(bitmap_height);
    pitch    = sat_dim(frame_pitch);
    ox_e     = {{2{origin_x[ORG_W-1]}}, origin_x};
    oy_e     = {{2{origin_y[ORG_W-1]}}, origin_y};
    maxx_raw = ox_e + $signed({3'd0, bw});
    maxy_raw = oy_e + $signed({3'd0, bh});
    if (origin_x[ORG_W-1]) begin
      minx_e = '0;
      offx_e = -ox_e;
    end else begin
      minx_e = ox_e;
      offx_e = '0;
    end
    if (origin_y[ORG_W-1]) begin
      miny_e = '0;
      offy_e = -oy_e;
    end else begin
      miny_e = oy_e;
      offy_e = '0;
    end
    maxx_e = (maxx_raw > $signed({3'd0, fw})) ? $signed({3'd0, fw}) : maxx_raw;
    maxy_e = (maxy_raw > $signed({3'd0, fh})) ? $signed({3'd0, fh}) : maxy_raw;
  end

  always_ff @(posedge clk) begin
    a_min_x  <= minx_e[DIM_W-1:0];
    a_min_y  <= miny_e[DIM_W-1:0];
    a_max_x  <= maxx_e;
    a_max_y  <= maxy_e;
    a_off_x  <= offx_e[ORG_W-1:0];
    a_off_y  <= offy_e[ORG_W-1:0];
    a_region <= (minx_e < maxx_e) && (miny_e < maxy_e);
    a_bw     <= bw;
    a_bh     <= bh;
    a_pitch  <= pitch;
  end

  // walk start values
  always_comb begin
    width_m1_e = a_max_x - 16'sd1 - $signed({3'd0, a_min_x});
    last_y_e   = a_max_y - 16'sd1;
    row_e      = $signed({3'd0, a_bh}) - 16'sd1 - $signed({2'd0, a_off_y});
    src_prod   = {13'd0, a_bw} * {13'd0, row_e[DIM_W-1:0]};
    dst_prod   = {13'd0, a_min_y} * {13'd0, a_pitch};
    src_start  = a_region ? (src_prod[IDX_W-1:0] + {10'd0, a_off_x}) : '0;
  end

  always_ff @(posedge clk) begin
    b_min_x     <= a_min_x;
    b_min_y     <= a_min_y;
    b_width_m1  <= width_m1_e[DIM_W-1:0];
    b_last_y    <= last_y_e[DIM_W-1:0];
    b_bw        <= a_bw;
    b_pitch     <= a_pitch;
    b_src_start <= src_start;
    b_dst_start <= dst_prod[IDX_W-1:0];
    b_region    <= a_region;
  end

  assign row_end = (col == b_width_m1);
  assign is_last = row_end && (cur_y == b_last_y);

  always_comb begin
    wr_item.src_pixel = pair.src_pixel;
    wr_item.dst_pixel = pair.dst_pixel;
    if (b_region) begin
      wr_item.dest_index   = dst_row + {11'd0, cur_x};
      wr_item.source_index = src_row + {11'd0, col};
      wr_item.is_last      = is_last;
      wr_item.in_region    = 1'b1;
    end else begin
      wr_item.dest_index   = '0;
      wr_item.source_index = '0;
      wr_item.is_last      = 1'b0;
      wr_item.in_region    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((busy == 2'd1) || (accept && b_region && is_last)) begin
      col     <= '0;
      cur_x   <= b_min_x;
      cur_y   <= b_min_y;
      src_row <= b_src_start;
      dst_row <= b_dst_start;
    end else if (accept && b_region) begin
      if (row_end) begin
        col     <= '0;
        cur_x   <= b_min_x;
        cur_y   <= cur_y + 13'd1;
        src_row <= src_row - {11'd0, b_bw};
        dst_row <= dst_row + {11'd0, b_pitch};
      end else begin
        col   <= col + 13'd1;
        cur_x <= cur_x + 13'd1;
      end
    end
  end

endmodule

// File: design/cabb_queue.sv
`timescale 1ns / 1ps

module cabb_queue import cabb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  work_t   wr_data,
  input  logic    rd_en,
  output work_t   rd_data,
  output q_stat_t stat
);

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/cabb_back.sv
`timescale 1ns / 1ps

module cabb_back import cabb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_stat_t q_stat,
  input  work_t   rd_data,
  output logic    rd_en,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  function automatic logic [15:0] blend_num(input logic [7:0] a, input logic [7:0] s,
                                            input logic [7:0] d);
    logic [15:0] p0, p1;
    p0 = {8'd0, 8'd255 - a} * {8'd0, d};
    p1 = {8'd0, a} * {8'd0, s};
    return p0 + p1;
  endfunction

  // rounded divide by 255
  function automatic logic [7:0] div255(input logic [15:0] num);
    logic [16:0] y, q;
    y = {1'b0, num} + 17'd127;
    q = (y + 17'd1 + {8'd0, y[16:8]}) >> 8;
    return q[7:0];
  endfunction

  logic        s1_valid, out_valid;
  logic [15:0] s1_r, s1_g, s1_b;
  logic [23:0] s1_dest, s1_src;
  logic        s1_last, s1_region;
  logic        out_load, s1_adv, s1_load;

  assign out_load = !out_valid || pop;
  assign s1_adv   = s1_valid && out_load;
  assign s1_load  = !s1_valid || s1_adv;
  assign rd_en    = !q_stat.empty && s1_load;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= rd_en;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r      <= blend_num(rd_data.src_pixel[31:24], rd_data.src_pixel[23:16],
                             rd_data.dst_pixel[23:16]);
      s1_g      <= blend_num(rd_data.src_pixel[31:24], rd_data.src_pixel[15:8],
                             rd_data.dst_pixel[15:8]);
      s1_b      <= blend_num(rd_data.src_pixel[31:24], rd_data.src_pixel[7:0],
                             rd_data.dst_pixel[7:0]);
      s1_dest   <= rd_data.dest_index;
      s1_src    <= rd_data.source_index;
      s1_last   <= rd_data.is_last;
      s1_region <= rd_data.in_region;
    end
    if (s1_adv) begin
      result.blended_pixel <= s1_region ? {div255(s1_r), div255(s1_g), div255(s1_b)} : '0;
      result.dest_index    <= s1_dest;
      result.source_index  <= s1_src;
      result.is_last       <= s1_last;
      result.in_region     <= s1_region;
    end
  end

endmodule

// File: design/clipped_alpha_blend_blit_top.sv
`timescale 1ns / 1ps
// clipped alpha blend blitter
// input queue side: push a pair item (source argb pixel, destination rgb pixel)
// while full is low; items are taken one per clock when nothing stalls
// output queue side: while empty is low the oldest result item is on result;
// pop takes it. items pass the queue, the blend stage and the output register
// sustained rate is one item per cycle while pop keeps up: the blend pipe is
// two stages fed from a four-entry queue behind the front walker
// front walks the clipped rectangle in raster order and tags each item with
// its destination and source indices and the last flag; an empty rectangle
// gives results with in_region low and zero fields
// config is an apb-style port, register i at byte address 4*i, always ready;
// a register write restarts the walk and holds full high while the clip
// rectangle and start indices are recomputed
// reset (synchronous, active high) loads default registers, empties the
// pipe and holds full high after release until the walk start is loaded
// when the receiver stalls, results back up into the queue and full rises

module clipped_alpha_blend_blit_top import cabb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  pair_t             pair,
  output logic              empty,
  input  logic              pop,
  output result_t           result
);

  q_stat_t q_stat;
  logic    q_wr, q_rd;
  work_t   q_wdata, q_rdata;

  cabb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .full    (full),
    .pair    (pair),
    .q_stat  (q_stat),
    .wr_en   (q_wr),
    .wr_item (q_wdata)
  );

  cabb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  cabb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .rd_data (q_rdata),
    .rd_en   (q_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_stat.full)
    else $error("queue written while full");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr[4:2] < 3'(REG_COUNT))) |=> full)
    else $error("input taken straight after a register write");

  a_reset_holds_input: assert property (@(posedge clk)
    rst |=> full)
    else $error("input taken straight after reset");

  a_empty_region: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.in_region) |->
      (result.blended_pixel == '0) && !result.is_last && (result.dest_index == '0))
    else $error("result outside region carries data");

endmodule
